// ===== rtl/core/deq_pkg.sv =====
// Shared field widths, action codes and result status type for the deque.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int unsigned ActionW = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned PosW    = 10;
  localparam int unsigned LengthW = 11;

  typedef enum logic [ActionW-1:0] {
    ACT_PUSH_LEFT  = 3'd0,
    ACT_PUSH_RIGHT = 3'd1,
    ACT_DROP_LEFT  = 3'd2,
    ACT_DROP_RIGHT = 3'd3,
    ACT_READ       = 3'd4
  } action_e;

  // Status of one word while its store read is in flight.
  typedef struct packed {
    logic [LengthW-1:0] length;
    logic               error_flag;
    logic               is_read;
  } deq_res_t;

endpackage

// ===== rtl/core/deq_if.sv =====
// Valid/ready channel interfaces for the deque command and result words.
`timescale 1ns / 1ps

interface deq_in_if;
  import deq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic        [ActionW-1:0] action;
  logic signed [ValueW-1:0]  value;
  logic        [CountW-1:0]  count;
  logic        [PosW-1:0]    position;

  modport source (output valid, action, value, count, position, input ready);
  modport sink   (input valid, action, value, count, position, output ready);
endinterface

interface deq_out_if;
  import deq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic        [LengthW-1:0] length;
  logic signed [ValueW-1:0]  read_word;
  logic                      error_flag;

  modport source (output valid, length, read_word, error_flag, input ready);
  modport sink   (input valid, length, read_word, error_flag, output ready);
endinterface

// ===== rtl/core/deque_with_bulk_drop.sv =====
// Top level of the double-ended queue with bulk drop and indexed read.
//
// Usage:
//   in_i  carries one command word: action (push left, push right, drop
//         left, drop right, read), value to push, count to drop and the
//         position to read, counted from the left end.
//   out_o returns exactly one result word per command: length after the
//         command, the word read (zero unless a read hit) and an error flag
//         (push into a full queue, or read at or beyond the length).
//   A drop of at least the length empties the queue; a drop on an empty
//   queue does nothing. Unused action codes only report the length.
// Pipeline: pointer update and store access happen at the accept edge;
//   the command's status waits in stage 1 while the store's registered
//   read port fetches the word, then the result register takes both. One
//   command per cycle is sustained while the receiver keeps taking results.
// Reset: left pointer and word count clear, both pipeline stages empty.
//   The ring store is not cleared; words are only read where written.
// Stall: a stalled receiver holds the result register; the stage behind it
//   holds one more command, after which in_i.ready drops.
`timescale 1ns / 1ps

module deque_with_bulk_drop #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  deq_in_if.sink        in_i,
  deq_out_if.source     out_o
);
  import deq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic              accept;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr;
  logic [ValueW-1:0] mem_wdata, mem_rdata;
  deq_res_t          res;

  // Stage 1: store read in flight
  logic              s1_valid_q;
  deq_res_t          s1_res_q;
  logic              s1_adv;

  // Stage 2: result register facing the receiver
  logic               out_valid_q;
  logic [LengthW-1:0] out_len_q;
  logic [ValueW-1:0]  out_word_q;
  logic               out_err_q;

  // Advance stage 1 when the result register is free or being emptied.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign accept     = in_i.valid && in_i.ready;

  deq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .action_i    (in_i.action),
    .value_i     (in_i.value),
    .count_i     (in_i.count),
    .position_i  (in_i.position),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .res_o       (res)
  );

  // Read data stays put until the next accepted read, which cannot happen
  // while stage 1 is stalled.
  deq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (ValueW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
    end
    if (s1_adv) begin
      out_len_q  <= s1_res_q.length;
      out_err_q  <= s1_res_q.error_flag;
      out_word_q <= s1_res_q.is_read ? mem_rdata : '0;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.length     = out_len_q;
  assign out_o.read_word  = out_word_q;
  assign out_o.error_flag = out_err_q;

endmodule

// ===== rtl/core/deq_ram.sv =====
// Ring store: single-port synchronous memory with a registered read port.
`timescale 1ns / 1ps

module deq_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/deq_ctrl.sv =====
// Deque pointers: left pointer and word count, store address and new length.
`timescale 1ns / 1ps

module deq_ctrl #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned CW    = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [deq_pkg::ActionW-1:0]   action_i,
  input  logic [deq_pkg::ValueW-1:0]    value_i,
  input  logic [deq_pkg::CountW-1:0]    count_i,
  input  logic [deq_pkg::PosW-1:0]      position_i,
  output logic                          mem_we_o,
  output logic                          mem_re_o,
  output logic [AW-1:0]                 mem_addr_o,
  output logic [deq_pkg::ValueW-1:0]    mem_wdata_o,
  output deq_pkg::deq_res_t             res_o
);
  import deq_pkg::*;

  // Compare width: wide enough for the count field and the word count.
  localparam int unsigned CmpW = (CW > CountW) ? CW : CountW;

  logic [AW-1:0]   left_q, left_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CmpW-1:0] cnt_ext, drop_ext, pos_ext;
  logic            full;

  // (base + off) mod DEPTH for base < DEPTH, off <= DEPTH
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign cnt_ext  = CmpW'(cnt_q);
  assign drop_ext = CmpW'(count_i);
  assign pos_ext  = CmpW'(position_i);
  assign full     = (cnt_q == CW'(DEPTH));

  always_comb begin
    left_d         = left_q;
    cnt_d          = cnt_q;
    mem_we_o       = 1'b0;
    mem_re_o       = 1'b0;
    mem_addr_o     = left_q;
    mem_wdata_o    = value_i;
    res_o.error_flag = 1'b0;
    res_o.is_read  = 1'b0;
    case (action_e'(action_i))
      ACT_PUSH_LEFT: begin
        if (full) begin
          res_o.error_flag = 1'b1;
        end else begin
          left_d     = (left_q == '0) ? AW'(DEPTH - 1) : left_q - AW'(1);
          cnt_d      = cnt_q + CW'(1);
          mem_we_o   = accept_i;
          mem_addr_o = left_d;
        end
      end
      ACT_PUSH_RIGHT: begin
        if (full) begin
          res_o.error_flag = 1'b1;
        end else begin
          cnt_d      = cnt_q + CW'(1);
          mem_we_o   = accept_i;
          mem_addr_o = ring_add(left_q, cnt_q);
        end
      end
      ACT_DROP_LEFT: begin
        if (drop_ext >= cnt_ext) begin
          cnt_d = '0;
        end else begin
          left_d = ring_add(left_q, drop_ext[CW-1:0]);
          cnt_d  = cnt_q - drop_ext[CW-1:0];
        end
      end
      ACT_DROP_RIGHT: begin
        if (drop_ext >= cnt_ext) begin
          cnt_d = '0;
        end else begin
          cnt_d = cnt_q - drop_ext[CW-1:0];
        end
      end
      ACT_READ: begin
        if (pos_ext < cnt_ext) begin
          res_o.is_read = 1'b1;
          mem_re_o      = accept_i;
          mem_addr_o    = ring_add(left_q, pos_ext[CW-1:0]);
        end else begin
          res_o.error_flag = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res_o.length = LengthW'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      cnt_q  <= '0;
    end else if (accept_i) begin
      left_q <= left_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/deq_checker.sv =====
// Port-level checker for the deque result channel, bound to the top level.
`timescale 1ns / 1ps

module deq_checker #(
  parameter int unsigned DEPTH = 1024
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [10:0] out_length_i,
  input logic [31:0] out_read_word_i,
  input logic        out_error_flag_i
);

  // An error result never carries a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_error_flag_i) |-> (out_read_word_i == '0))
    else $error("error result carries a nonzero word");

  // The reported length never exceeds the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((DEPTH > 2047) || (32'(out_length_i) <= 32'(DEPTH))))
    else $error("length beyond depth");

  // No result right after reset: both stages start empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_i)
    else $error("result valid right after reset");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_length_i) && $stable(out_read_word_i)
       && $stable(out_error_flag_i)))
    else $error("stalled result changed");

endmodule

bind deque_with_bulk_drop deq_checker #(
  .DEPTH (DEPTH)
) u_deq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_length_i     (out_o.length),
  .out_read_word_i  (out_o.read_word),
  .out_error_flag_i (out_o.error_flag)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the double-ended queue with bulk drop and indexed read.
`timescale 1ns / 1ps

module testbench;
  import deq_pkg::*;

  // Ring size of the block under test; positions span the whole ring.
  localparam int unsigned Depth        = 1024;
  localparam int unsigned ResetCycles  = 11;
  // Idle cycles on both channels before the run is declared hung. The long
  // receiver hold-off (HoldOffLen) is far below this.
  localparam int unsigned HangLimit    = 5000;
  // Cycles to watch for stray replies once nothing is outstanding.
  localparam int unsigned DrainCycles  = 10;
  localparam int unsigned HoldOffAfter = 200;
  localparam int unsigned HoldOffLen   = 400;
  // Codes 5 to 7 carry no action; the block only reports the length.
  localparam int unsigned FirstSpareAction = 5;
  localparam int unsigned LastSpareAction  = (1 << ActionW) - 1;

  typedef struct packed {
    logic [ActionW-1:0]       action;
    logic signed [ValueW-1:0] value;
    logic [CountW-1:0]        count;
    logic [PosW-1:0]          position;
  } deq_cmd_t;

  typedef struct packed {
    logic [LengthW-1:0]       length;
    logic signed [ValueW-1:0] read_word;
    logic                     error_flag;
  } deq_reply_t;

  // Receiver behavior for a stretch of cycles.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_CHOPPY,
    RX_SPARSE
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;

  deq_in_if  cmd_if ();
  deq_out_if reply_if ();

  deque_with_bulk_drop #(
    .DEPTH (Depth)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (reply_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Shadow deque: the words held, the left end and the fill level, kept
  // in step with every command word the block accepts.
  // ---------------------------------------------------------------------
  logic [ValueW-1:0] shadow_ring [Depth];
  int unsigned       shadow_head  = 0;
  int unsigned       shadow_held  = 0;

  // Run statistics for the summary.
  int unsigned deepest_fill   = 0;
  int unsigned refused_pushes = 0;
  int unsigned read_hits      = 0;
  int unsigned read_misses    = 0;

  // Apply one command to the shadow deque and work out the reply word.
  task automatic deque_step(input deq_cmd_t cmd, output deq_reply_t reply);
    reply = '0;
    case (cmd.action)
      ACT_PUSH_LEFT: begin
        if (shadow_held >= Depth) begin
          reply.error_flag = 1'b1;
          refused_pushes++;
        end else begin
          shadow_head = (shadow_head + Depth - 1) % Depth;
          shadow_ring[shadow_head] = cmd.value;
          shadow_held++;
        end
      end
      ACT_PUSH_RIGHT: begin
        if (shadow_held >= Depth) begin
          reply.error_flag = 1'b1;
          refused_pushes++;
        end else begin
          shadow_ring[(shadow_head + shadow_held) % Depth] = cmd.value;
          shadow_held++;
        end
      end
      ACT_DROP_LEFT: begin
        // Dropping at least the fill level empties the queue; an empty
        // queue or a zero count leaves it as it is.
        if (cmd.count >= shadow_held) begin
          shadow_held = 0;
        end else begin
          shadow_head = (shadow_head + cmd.count) % Depth;
          shadow_held -= cmd.count;
        end
      end
      ACT_DROP_RIGHT: begin
        if (cmd.count >= shadow_held) begin
          shadow_held = 0;
        end else begin
          shadow_held -= cmd.count;
        end
      end
      ACT_READ: begin
        if (cmd.position < shadow_held) begin
          reply.read_word = shadow_ring[(shadow_head + cmd.position) % Depth];
          read_hits++;
        end else begin
          reply.error_flag = 1'b1;
          read_misses++;
        end
      end
      default: begin
      end
    endcase
    reply.length = LengthW'(shadow_held);
    if (shadow_held > deepest_fill) begin
      deepest_fill = shadow_held;
    end
  endtask

  // ---------------------------------------------------------------------
  // Command plan. The initial block fills pending_cmds up front; the
  // planner tracks the fill level on its own so it can aim reads inside
  // the queue and steer the queue all the way to full.
  // ---------------------------------------------------------------------
  deq_cmd_t    pending_cmds [$];
  deq_reply_t  pending_replies [$];
  int unsigned plan_len = 0;

  task automatic plan_cmd(input logic [ActionW-1:0] act, input logic [ValueW-1:0] val,
                          input logic [CountW-1:0] cnt, input logic [PosW-1:0] pos);
    deq_cmd_t c;
    c.action   = act;
    c.value    = val;
    c.count    = cnt;
    c.position = pos;
    pending_cmds.insert(pending_cmds.size(), c);
    case (act)
      ACT_PUSH_LEFT, ACT_PUSH_RIGHT: begin
        if (plan_len < Depth) begin
          plan_len++;
        end
      end
      ACT_DROP_LEFT, ACT_DROP_RIGHT: begin
        plan_len = (cnt >= plan_len) ? 0 : plan_len - cnt;
      end
      default: begin
      end
    endcase
  endtask

  // Mostly a position inside the queue, sometimes anywhere in the field.
  function automatic logic [PosW-1:0] pick_position();
    if (plan_len > 0 && $urandom_range(0, 9) < 7) begin
      return PosW'($urandom_range(0, plan_len - 1));
    end
    return PosW'($urandom_range(0, (1 << PosW) - 1));
  endfunction

  // One command from the general mix: pushes both ways, short and long
  // drops, reads, and now and then a spare action code.
  task automatic plan_random_cmd();
    int unsigned pick;
    logic [CountW-1:0] cnt;
    pick = $urandom_range(0, 99);
    cnt  = ($urandom_range(0, 99) < 85) ? CountW'($urandom_range(0, 4))
                                        : CountW'($urandom_range(0, (1 << CountW) - 1));
    if (pick < 30) begin
      plan_cmd(ACT_PUSH_LEFT, $urandom, cnt, pick_position());
    end else if (pick < 60) begin
      plan_cmd(ACT_PUSH_RIGHT, $urandom, cnt, pick_position());
    end else if (pick < 72) begin
      plan_cmd(ACT_DROP_LEFT, $urandom, cnt, pick_position());
    end else if (pick < 84) begin
      plan_cmd(ACT_DROP_RIGHT, $urandom, cnt, pick_position());
    end else if (pick < 97) begin
      plan_cmd(ACT_READ, $urandom, cnt, pick_position());
    end else begin
      plan_cmd(ActionW'($urandom_range(FirstSpareAction, LastSpareAction)), $urandom, cnt,
               pick_position());
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps. A word on
  // the bus is held until the block takes it; the next one goes out at
  // the same edge so a back-to-back burst never drops valid.
  // ---------------------------------------------------------------------
  deq_cmd_t    live_cmd    = '0;
  deq_reply_t  fresh_reply;
  logic        offer;
  int unsigned burst_left  = 0;
  int unsigned gap_left    = 0;
  int unsigned cmds_taken  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid    <= 1'b0;
      cmd_if.action   <= '0;
      cmd_if.value    <= '0;
      cmd_if.count    <= '0;
      cmd_if.position <= '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        deque_step(live_cmd, fresh_reply);
        pending_replies.insert(pending_replies.size(), fresh_reply);
        cmds_taken++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (burst_left == 0 && gap_left == 0) begin
          // A quarter of the bursts follow on with no gap at all.
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          burst_left = $urandom_range(1, 40);
        end
        if (gap_left > 0) begin
          gap_left--;
          offer = 1'b0;
        end else if (pending_cmds.size() != 0) begin
          live_cmd = pending_cmds.pop_front();
          offer    = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end
        end else begin
          offer = 1'b0;
        end
        cmd_if.valid    <= offer;
        cmd_if.action   <= live_cmd.action;
        cmd_if.value    <= live_cmd.value;
        cmd_if.count    <= live_cmd.count;
        cmd_if.position <= live_cmd.position;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: switch between open, choppy and sparse stretches. Once,
  // after a couple hundred replies, hold off for a long stretch so the
  // block fills up and pushes back on the command side.
  // ---------------------------------------------------------------------
  rx_mode_e    rx_mode      = RX_OPEN;
  int unsigned rx_mode_left = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_taken     = 0;
  bit          rx_held_once = 1'b0;
  logic        take;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reply_if.ready <= 1'b0;
    end else begin
      if (reply_if.valid && reply_if.ready) begin
        rx_taken++;
      end
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(16, 120);
      end
      rx_mode_left--;
      if (!rx_held_once && rx_taken >= HoldOffAfter) begin
        rx_held_once = 1'b1;
        rx_hold_left = HoldOffLen;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        take = 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   take = 1'b1;
          RX_CHOPPY: take = 1'($urandom_range(0, 1));
          default:   take = ($urandom_range(0, 3) == 0);
        endcase
      end
      reply_if.ready <= take;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every reply word taken is matched against the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------
  deq_reply_t  due_reply;
  int unsigned replies_checked = 0;
  int unsigned fail_count      = 0;

  always @(posedge clk_i) begin
    if (rst_ni && reply_if.valid && reply_if.ready) begin
      if (pending_replies.size() == 0) begin
        $error("reply word with nothing outstanding: length %0d read_word %0d error_flag %0b",
               reply_if.length, reply_if.read_word, reply_if.error_flag);
        fail_count++;
      end else begin
        due_reply = pending_replies.pop_front();
        replies_checked++;
        if (reply_if.length !== due_reply.length) begin
          $error("length: expected %0d, got %0d", due_reply.length, reply_if.length);
          fail_count++;
        end
        if (reply_if.read_word !== due_reply.read_word) begin
          $error("read_word: expected %0d, got %0d", due_reply.read_word, reply_if.read_word);
          fail_count++;
        end
        if (reply_if.error_flag !== due_reply.error_flag) begin
          $error("error_flag: expected %0b, got %0b", due_reply.error_flag,
                 reply_if.error_flag);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: end the run if neither channel moves a word for too long.
  // ---------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (reply_if.valid && reply_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HangLimit) begin
        $error("no handshake for %0d cycles, %0d replies still outstanding", HangLimit,
               pending_replies.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus plan, reset and end of run.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned n;

    // Hold the block in reset from time zero.
    rst_ni            = 1'b0;

    // Directed: value extremes at both ends, reads inside and past the
    // end, zero-length and oversized drops, drops and reads on an empty
    // queue, and the spare action codes.
    plan_cmd(ACT_PUSH_LEFT,  32'h8000_0000, '0, '0);
    plan_cmd(ACT_PUSH_RIGHT, 32'h7FFF_FFFF, '0, '0);
    plan_cmd(ACT_PUSH_LEFT,  32'hFFFF_FFFF, '0, '0);
    plan_cmd(ACT_PUSH_RIGHT, 32'h0000_0000, '0, '0);
    for (n = 0; n < 4; n++) begin
      plan_cmd(ACT_READ, '0, '0, PosW'(n));
    end
    plan_cmd(ACT_READ,       '0, '0, PosW'(4));
    plan_cmd(ACT_READ,       '0, '0, '1);
    plan_cmd(ACT_DROP_LEFT,  '0, '0, '0);
    plan_cmd(ACT_DROP_RIGHT, '0, '0, '0);
    plan_cmd(ACT_DROP_LEFT,  '0, CountW'(1), '0);
    plan_cmd(ACT_READ,       '0, '0, '0);
    plan_cmd(ACT_DROP_RIGHT, '0, CountW'(1), '0);
    plan_cmd(ACT_READ,       '0, '0, PosW'(1));
    plan_cmd(ACT_DROP_LEFT,  '0, '1, '0);
    plan_cmd(ACT_DROP_RIGHT, '0, CountW'(5), '0);
    plan_cmd(ACT_DROP_LEFT,  '0, CountW'(3), '0);
    plan_cmd(ACT_READ,       '0, '0, '0);
    for (n = FirstSpareAction; n <= LastSpareAction; n++) begin
      plan_cmd(ActionW'(n), 32'h5A5A_A5A5, '1, '1);
    end
    plan_cmd(ACT_PUSH_RIGHT, 32'h1234_5678, '0, '0);
    plan_cmd(ACT_READ,       '0, '0, '0);

    // Random mix at low fill levels.
    repeat (40) plan_random_cmd();

    // Fill to the brim: mostly pushes at either end, a few reads on the way.
    while (plan_len < Depth) begin
      if ($urandom_range(0, 99) < 96) begin
        plan_cmd($urandom_range(0, 1) ? ACT_PUSH_LEFT : ACT_PUSH_RIGHT, $urandom,
                 CountW'($urandom), PosW'($urandom));
      end else begin
        plan_cmd(ACT_READ, $urandom, CountW'($urandom), pick_position());
      end
    end

    // Full queue: refused pushes at either end, reads at the far corners and at random.
    repeat (4) begin
      plan_cmd($urandom_range(0, 1) ? ACT_PUSH_LEFT : ACT_PUSH_RIGHT, $urandom, '0, '0);
    end
    plan_cmd(ACT_READ, '0, '0, '1);
    plan_cmd(ACT_READ, '0, '0, '0);
    plan_cmd(ACT_READ, '0, '0, PosW'($urandom));

    // Trim both ends in bulk and refill a little, then mix again.
    plan_cmd(ACT_DROP_LEFT,  '0, CountW'($urandom_range(1, 300)), '0);
    plan_cmd(ACT_PUSH_LEFT,  $urandom, '0, '0);
    plan_cmd(ACT_READ,       '0, '0, '0);
    plan_cmd(ACT_DROP_RIGHT, '0, CountW'($urandom_range(1, 300)), '0);
    plan_cmd(ACT_PUSH_RIGHT, $urandom, '0, '0);
    plan_cmd(ACT_READ,       '0, '0, PosW'(plan_len - 1));
    plan_cmd(ACT_READ,       '0, '0, pick_position());
    repeat (40) plan_random_cmd();

    // Reset once, then let the driver work through the plan.
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every command is taken and every reply has come back.
    do begin
      @(negedge clk_i);
    end while (pending_cmds.size() != 0 || cmd_if.valid || pending_replies.size() != 0);

    // Watch for stray replies before the summary.
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d commands and checked %0d replies; queue reached %0d of %0d words.",
             cmds_taken, replies_checked, deepest_fill, Depth);
    $display("Pushes refused when full: %0d, reads inside the queue: %0d, past its end: %0d.",
             refused_pushes, read_hits, read_misses);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
